### hdl/u8u16_pkg.sv
`timescale 1ns / 1ps
// Shared types, byte classes and helpers for the UTF-8 to UTF-16 decoder.
// Depends on nothing; every other file of the decoder imports it.
package u8u16_pkg;

    // One incoming word: a byte of UTF-8 text and the end-of-text mark.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_item_t;

    // One outgoing word: a code unit and its framing marks.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_of_run;
        logic        end_of_text;
    } out_item_t;

    localparam int MaxUnits = 3;

    // Work for the back end: the code units caused by one input byte.
    typedef struct packed {
        logic [1:0]                 count;
        logic [MaxUnits-1:0][15:0]  units;
        logic                       eot;
    } job_t;

    // Number of bytes held while a sequence is incomplete.
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_LEAD = 2'd1;
    localparam logic [1:0] HELD_BOTH = 2'd2;

    localparam logic [7:0] MASK_HI2  = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] MASK_HI3  = 8'hE0;
    localparam logic [7:0] MASK_LO4  = 8'h0F;
    localparam logic [7:0] MASK_LO5  = 8'h1F;
    localparam logic [7:0] MASK_LO6  = 8'h3F;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & MASK_HI2) == CONT_TAG;
    endfunction

    // Append one code unit to a job; units beyond the capacity are dropped.
    function automatic job_t job_push(input job_t j, input logic [15:0] u);
        job_t r;
        r = j;
        if (j.count != 2'd3)
        begin
            r.units[j.count] = u;
            r.count = j.count + 2'd1;
        end
        return r;
    endfunction

    function automatic logic [15:0] raw_unit(input logic [7:0] b);
        return {8'h00, b};
    endfunction

endpackage

### hdl/u8u16_front.sv
`timescale 1ns / 1ps
// Front end: accepts bytes, tracks the pending sequence and builds one job per byte.
// Depends on u8u16_pkg.
module u8u16_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  u8u16_pkg::in_item_t byte_item,
    input  logic              queue_full,
    output logic              job_push_en,
    output u8u16_pkg::job_t   job
);
    import u8u16_pkg::*;

    logic [7:0] lead_held_reg, lead_held_next;
    logic [7:0] cont_held_reg, cont_held_next;
    logic [1:0] held_count_reg, held_count_next;
    logic       accept;

    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;

    // Decode the new byte against what is pending and collect the units it causes.
    always_comb
    begin
        logic [7:0] b;
        logic       do_fresh;
        job_t       j;
        b               = byte_item.in_byte;
        do_fresh        = 1'b0;
        j               = '0;
        lead_held_next  = lead_held_reg;
        cont_held_next  = cont_held_reg;
        held_count_next = HELD_NONE;

        case (held_count_reg)
            HELD_LEAD:
            begin
                if (is_cont(b))
                begin
                    if ((lead_held_reg & MASK_HI3) == MASK_HI3)
                    begin
                        cont_held_next  = b;
                        held_count_next = HELD_BOTH;
                    end
                    else
                    begin
                        j = job_push(j, {5'd0, lead_held_reg[4:0], 6'd0} |
                                        {10'd0, b[5:0]});
                    end
                end
                else
                begin
                    j        = job_push(j, raw_unit(lead_held_reg));
                    do_fresh = 1'b1;
                end
            end
            HELD_BOTH:
            begin
                if (is_cont(b))
                begin
                    j = job_push(j, {lead_held_reg[3:0], cont_held_reg[5:0], b[5:0]});
                end
                else
                begin
                    j        = job_push(j, raw_unit(lead_held_reg));
                    j        = job_push(j, raw_unit(cont_held_reg));
                    do_fresh = 1'b1;
                end
            end
            default:
            begin
                do_fresh = 1'b1;
            end
        endcase

        // A byte seen with nothing pending: ASCII, a new lead, or a stray continuation.
        if (do_fresh)
        begin
            if ((b & MASK_HI2) == MASK_HI2)
            begin
                lead_held_next  = b;
                held_count_next = HELD_LEAD;
            end
            else
            begin
                j = job_push(j, raw_unit(b));
            end
        end

        // End of text flushes whatever is still pending, oldest first.
        if (byte_item.last_byte)
        begin
            if (held_count_next != HELD_NONE)
            begin
                j = job_push(j, raw_unit(lead_held_next));
            end
            if (held_count_next == HELD_BOTH)
            begin
                j = job_push(j, raw_unit(cont_held_next));
            end
            held_count_next = HELD_NONE;
        end

        j.eot = byte_item.last_byte;
        job   = j;
    end

    assign job_push_en = accept && (job.count != 2'd0);

    // Pending-sequence state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_held_reg  <= '0;
            cont_held_reg  <= '0;
            held_count_reg <= HELD_NONE;
        end
        else if (accept)
        begin
            lead_held_reg  <= lead_held_next;
            cont_held_reg  <= cont_held_next;
            held_count_reg <= held_count_next;
        end
    end

endmodule

### hdl/u8u16_job_fifo.sv
`timescale 1ns / 1ps
// Two-entry job queue between the front end and the back end.
// Depends on u8u16_pkg.
module u8u16_job_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  u8u16_pkg::job_t push_job,
    input  logic            pop,
    output u8u16_pkg::job_t head_job,
    output logic            not_empty,
    output logic            full
);
    import u8u16_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head_job  = entry_reg[rd_ptr_reg];
    assign not_empty = count_reg != 2'd0;
    assign full      = count_reg == 2'd2;

    // Pointer and fill-count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### hdl/u8u16_back.sv
`timescale 1ns / 1ps
// Back end: walks head-job units into the output register, one per unstalled cycle.
// Depends on u8u16_pkg.
module u8u16_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  u8u16_pkg::job_t      head_job,
    input  logic                 head_valid,
    output logic                 pop,
    output logic                 unit_valid,
    input  logic                 unit_ready,
    output u8u16_pkg::out_item_t unit_item
);
    import u8u16_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_item_reg, out_item_next;
    logic       load;
    logic       final_unit;

    assign load       = head_valid && (!out_valid_reg || unit_ready);
    assign final_unit = idx_reg == (head_job.count - 2'd1);
    assign pop        = load && final_unit;

    // Select the next unit of the head job and mark the end of its run.
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (load)
        begin
            out_valid_next            = 1'b1;
            out_item_next.code_unit   = head_job.units[idx_reg];
            out_item_next.last_of_run = final_unit;
            out_item_next.end_of_text = final_unit && head_job.eot;
            idx_next                  = final_unit ? 2'd0 : idx_reg + 2'd1;
        end
        else if (unit_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign unit_valid = out_valid_reg;
    assign unit_item  = out_item_reg;

endmodule

### hdl/utf8_to_utf16_decoder_core.sv
`timescale 1ns / 1ps
// Top level of the UTF-8 to UTF-16 decoder: front end, job queue and back end.
// Depends on u8u16_pkg, u8u16_front, u8u16_job_fifo and u8u16_back.
//
// Usage: bytes of UTF-8 text enter on the byte channel (byte_valid, byte_ready,
// byte_item), one word per byte, with last_byte set on the final byte of a text.
// Code units leave on the unit channel (unit_valid, unit_ready, unit_item); each
// carries last_of_run on the last unit caused by one byte and end_of_text on the
// final unit of a text. A byte that only extends a pending sequence yields nothing.
// Each unit passes through the job queue and then the output register on its way
// to the unit channel. Throughput: one byte per cycle while each byte yields at
// most one unit and the receiver takes every unit; a byte that yields two or three
// units holds the back end until each is loaded, since the output register takes
// one unit per cycle at most. The two-entry job queue lets the front end keep
// taking bytes during such a run until the queue fills.
// Reset clears the pending sequence, the queue and the output register.
// When the receiver stalls, the output word holds, the queue fills and then
// byte_ready drops until space returns.
module utf8_to_utf16_decoder_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  u8u16_pkg::in_item_t  byte_item,
    output logic                 unit_valid,
    input  logic                 unit_ready,
    output u8u16_pkg::out_item_t unit_item
);
    import u8u16_pkg::*;

    job_t front_job;
    job_t head_job;
    logic job_push_en;
    logic queue_full;
    logic head_valid;
    logic pop;

    // Byte classification and pending-sequence tracking.
    u8u16_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_item   (byte_item),
        .queue_full  (queue_full),
        .job_push_en (job_push_en),
        .job         (front_job)
    );

    // Decouples the front end from stalls on the output side.
    u8u16_job_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push_en),
        .push_job  (front_job),
        .pop       (pop),
        .head_job  (head_job),
        .not_empty (head_valid),
        .full      (queue_full)
    );

    // Unit sequencing and output register.
    u8u16_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .head_valid (head_valid),
        .pop        (pop),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit_item  (unit_item)
    );

endmodule

### tb/tb_utf8_to_utf16_decoder_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf8_to_utf16_decoder_core: directed table, then random UTF-8 text.
// Depends on u8u16_pkg and the decoder RTL; expected units come from the table or a bench decoder.
module tb_utf8_to_utf16_decoder_core;

    import u8u16_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RANDOM_BYTES   = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int MAX_REPORTS    = 10;
    localparam int NUM_ROWS       = 26;

    // One row of the directed table; when typed_exp is set the code units are given here.
    typedef struct packed {
        logic [7:0]  data;
        logic        end_mark;
        logic        typed_exp;
        logic [1:0]  count;
        logic [15:0] u0;
        logic [15:0] u1;
        logic [15:0] u2;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_ready;
    in_item_t   byte_item;
    logic       unit_valid;
    logic       unit_ready = 1'b0;
    out_item_t  unit_item;

    // Decoder state as the testbench sees it.
    logic [7:0]  held_lead;
    logic [7:0]  held_cont;
    logic [1:0]  held_n;
    logic [15:0] step_units[$];
    out_item_t   due_units[$];

    int fault_count;
    int bytes_taken;
    int units_checked;
    int multi_unit_bytes;
    int burst_left;
    int idle_cycles;
    int rx_tick;
    int rx_mode;

    dir_row_t dir_rows [NUM_ROWS] = '{
        '{8'h00, 1'b0, 1'b1, 2'd1, 16'h0000, 16'h0000, 16'h0000},
        '{8'h7F, 1'b0, 1'b1, 2'd1, 16'h007F, 16'h0000, 16'h0000},
        '{8'h80, 1'b0, 1'b1, 2'd1, 16'h0080, 16'h0000, 16'h0000},
        '{8'hBF, 1'b0, 1'b1, 2'd1, 16'h00BF, 16'h0000, 16'h0000},
        '{8'hC0, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'h80, 1'b0, 1'b1, 2'd1, 16'h0000, 16'h0000, 16'h0000},
        '{8'hDF, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'hBF, 1'b0, 1'b1, 2'd1, 16'h07FF, 16'h0000, 16'h0000},
        '{8'hE0, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'h80, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'h80, 1'b0, 1'b1, 2'd1, 16'h0000, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'hBF, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'hBF, 1'b0, 1'b1, 2'd1, 16'hFFFF, 16'h0000, 16'h0000},
        '{8'hC5, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'h41, 1'b0, 1'b1, 2'd2, 16'h00C5, 16'h0041, 16'h0000},
        '{8'hEA, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'h95, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'hD0, 1'b0, 1'b1, 2'd2, 16'h00EA, 16'h0095, 16'h0000},
        '{8'hF3, 1'b0, 1'b1, 2'd1, 16'h00D0, 16'h0000, 16'h0000},
        '{8'h88, 1'b1, 1'b1, 2'd2, 16'h00F3, 16'h0088, 16'h0000},
        '{8'hE1, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'h92, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'hC3, 1'b1, 1'b1, 2'd3, 16'h00E1, 16'h0092, 16'h00C3},
        '{8'hC2, 1'b1, 1'b1, 2'd1, 16'h00C2, 16'h0000, 16'h0000},
        '{8'h00, 1'b1, 1'b1, 2'd1, 16'h0000, 16'h0000, 16'h0000}
    };

    utf8_to_utf16_decoder_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit_item  (unit_item)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // A byte with nothing pending either starts a sequence or leaves as a raw unit.
    task automatic start_fresh(input logic [7:0] b);
        if ((b & MASK_HI2) == MASK_HI2)
        begin
            held_lead = b;
            held_n = HELD_LEAD;
        end
        else
        begin
            step_units.push_back({8'h00, b});
        end
    endtask

    // Advance the decoder state by one byte and collect the code units it releases.
    task automatic decode_utf8_byte(input in_item_t w);
        logic cont_b;
        cont_b = (w.in_byte & MASK_HI2) == CONT_TAG;
        step_units.delete();
        if (held_n == HELD_LEAD)
        begin
            if (cont_b && (held_lead & MASK_HI3) == MASK_HI3)
            begin
                held_cont = w.in_byte;
                held_n = HELD_BOTH;
            end
            else if (cont_b)
            begin
                step_units.push_back(({8'h00, held_lead & MASK_LO5} << 6)
                                     | {8'h00, w.in_byte & MASK_LO6});
                held_n = HELD_NONE;
            end
            else
            begin
                // Broken two-byte sequence: the lead goes out raw.
                step_units.push_back({8'h00, held_lead});
                held_n = HELD_NONE;
                start_fresh(w.in_byte);
            end
        end
        else if (held_n == HELD_BOTH)
        begin
            if (cont_b)
            begin
                step_units.push_back(({8'h00, held_lead & MASK_LO4} << 12)
                                     | ({8'h00, held_cont & MASK_LO6} << 6)
                                     | {8'h00, w.in_byte & MASK_LO6});
                held_n = HELD_NONE;
            end
            else
            begin
                // Broken three-byte sequence: lead, then held continuation, both raw.
                step_units.push_back({8'h00, held_lead});
                step_units.push_back({8'h00, held_cont});
                held_n = HELD_NONE;
                start_fresh(w.in_byte);
            end
        end
        else
        begin
            held_n = HELD_NONE;
            start_fresh(w.in_byte);
        end
        // End of text flushes whatever is still pending, in arrival order.
        if (w.last_byte)
        begin
            if (held_n != HELD_NONE)
                step_units.push_back({8'h00, held_lead});
            if (held_n == HELD_BOTH)
                step_units.push_back({8'h00, held_cont});
            held_n = HELD_NONE;
        end
    endtask

    // Turn the collected code units into expected output words with their marks.
    task automatic queue_results(input logic end_mark);
        out_item_t o;
        for (int k = 0; k < step_units.size(); k++)
        begin
            o.code_unit   = step_units[k];
            o.last_of_run = (k == step_units.size() - 1);
            o.end_of_text = o.last_of_run && end_mark;
            due_units.push_back(o);
        end
        if (step_units.size() > 1)
            multi_unit_bytes++;
    endtask

    // Hand one word to the decoder, in bursts separated by random gaps.
    task automatic send_word(input in_item_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                byte_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        byte_valid <= 1'b1;
        byte_item  <= w;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        burst_left--;
        bytes_taken++;
        decode_utf8_byte(w);
    endtask

    // Send a random byte and predict what it yields; end of text is set now and then.
    task automatic send_random(input logic [7:0] b);
        in_item_t w;
        w.in_byte   = b;
        w.last_byte = ($urandom_range(0, 29) == 0);
        send_word(w);
        queue_results(w.last_byte);
    endtask

    // Receiver stalls follow a random mode that is redrawn periodically as rx_tick advances.
    always @(negedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 48 == 0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: unit_ready <= 1'b1;
            1: unit_ready <= rx_tick[0];
            2: unit_ready <= ($urandom_range(0, 3) != 0);
            default: unit_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Compare each accepted output word with the oldest expected one.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && unit_valid && unit_ready)
        begin
            if (due_units.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("%0t: unexpected word unit=%h run=%b eot=%b", $realtime,
                             unit_item.code_unit, unit_item.last_of_run,
                             unit_item.end_of_text);
            end
            else
            begin
                want = due_units.pop_front();
                units_checked++;
                if (unit_item.code_unit !== want.code_unit
                    || unit_item.last_of_run !== want.last_of_run
                    || unit_item.end_of_text !== want.end_of_text)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display({"%0t: mismatch exp unit=%h run=%b eot=%b",
                                  " got unit=%h run=%b eot=%b"},
                                 $realtime, want.code_unit, want.last_of_run,
                                 want.end_of_text, unit_item.code_unit,
                                 unit_item.last_of_run, unit_item.end_of_text);
                end
            end
        end
    end

    // Watchdog: too many cycles without a word moving on either side ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && byte_ready) || (unit_valid && unit_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d words outstanding", due_units.size());
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        in_item_t w;
        int kind;
        int random_sent;
        logic [7:0] lead;

        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_item = '0;
        held_lead = '0;
        held_cont = '0;
        held_n = HELD_NONE;
        fault_count = 0;
        bytes_taken = 0;
        units_checked = 0;
        multi_unit_bytes = 0;
        burst_left = 0;
        idle_cycles = 0;
        rx_tick = 0;
        rx_mode = 0;
        random_sent = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table: extremes, each sequence length, broken sequences, end of text.
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            w.in_byte   = dir_rows[r].data;
            w.last_byte = dir_rows[r].end_mark;
            send_word(w);
            if (dir_rows[r].typed_exp)
            begin
                step_units.delete();
                if (dir_rows[r].count > 0)
                    step_units.push_back(dir_rows[r].u0);
                if (dir_rows[r].count > 1)
                    step_units.push_back(dir_rows[r].u1);
                if (dir_rows[r].count > 2)
                    step_units.push_back(dir_rows[r].u2);
            end
            queue_results(w.last_byte);
        end

        // Random text: mostly well-formed sequences, some broken ones and noise.
        while (random_sent < RANDOM_BYTES)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 30)
            begin
                send_random(8'($urandom_range(8'h00, 8'h7F)));
                random_sent += 1;
            end
            else if (kind < 55)
            begin
                send_random(8'($urandom_range(8'hC0, 8'hDF)));
                send_random(8'($urandom_range(8'h80, 8'hBF)));
                random_sent += 2;
            end
            else if (kind < 80)
            begin
                send_random(8'($urandom_range(8'hE0, 8'hFF)));
                send_random(8'($urandom_range(8'h80, 8'hBF)));
                send_random(8'($urandom_range(8'h80, 8'hBF)));
                random_sent += 3;
            end
            else if (kind < 88)
            begin
                // A lead, perhaps one continuation, then a byte that breaks the sequence.
                lead = 8'($urandom_range(8'hC0, 8'hFF));
                send_random(lead);
                random_sent += 1;
                if ((lead & MASK_HI3) == MASK_HI3 && $urandom_range(0, 1) == 1)
                begin
                    send_random(8'($urandom_range(8'h80, 8'hBF)));
                    random_sent += 1;
                end
                if ($urandom_range(0, 1) == 1)
                    send_random(8'($urandom_range(8'h00, 8'h7F)));
                else
                    send_random(8'($urandom_range(8'hC0, 8'hFF)));
                random_sent += 1;
            end
            else if (kind < 94)
            begin
                send_random(8'($urandom_range(8'h80, 8'hBF)));
                random_sent += 1;
            end
            else
            begin
                send_random(8'($urandom_range(8'h00, 8'hFF)));
                random_sent += 1;
            end
        end

        // Close the text so nothing stays pending.
        w.in_byte   = 8'($urandom_range(8'h00, 8'h7F));
        w.last_byte = 1'b1;
        send_word(w);
        queue_results(w.last_byte);

        @(negedge clk);
        byte_valid <= 1'b0;
        while (due_units.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes (%0d from the directed table), checked %0d code units;",
                 bytes_taken, NUM_ROWS, units_checked);
        $display("%0d bytes released several units, %0d mismatches seen.",
                 multi_unit_bytes, fault_count);
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
hdl/u8u16_pkg.sv
hdl/u8u16_front.sv
hdl/u8u16_job_fifo.sv
hdl/u8u16_back.sv
hdl/utf8_to_utf16_decoder_core.sv
tb/tb_utf8_to_utf16_decoder_core.sv
